### rtl/core/hcb_pkg.sv
// Shared widths and sizing constants for the Huffman code builder.
`timescale 1ns / 1ps
package hcb_pkg;
    localparam int HCB_MAX_SYMBOLS = 16;
    localparam int SYM_W           = 8;
    localparam int FREQ_W          = 20;
    localparam int CODE_W          = 15;
    localparam int LEN_W           = 4;
    localparam int IN_DATA_W       = 32;
    localparam int OUT_DATA_W      = 32;
endpackage

### rtl/core/huffman_code_builder.sv
// Huffman code builder: symbol load, memory-based merge scans and a depth-first code walk.
// Operation: n load beats, then n-1 merges, each a scan of every node made so far and a write of
// the merged node, then a depth-first walk that pops, reads and visits each node in turn.
// Throughput: one set at a time; the merge scan over the weight memory read port sets the rate.
// Input beats are taken only in the load phase; the walk stalls while a result beat waits.
// Reset (aresetn low, synchronous) clears the phase, counters, active bits and output valid;
// the memories keep their contents and are always written before they are read.
`timescale 1ns / 1ps
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = HCB_MAX_SYMBOLS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // symbol[7:0], frequency[27:8], zeros above
    input  logic                  s_tlast,   // last_symbol
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_symbol[7:0], code_bits[22:8],
                                             // code_length[26:23], zeros above
    output logic                  m_tlast    // last_code
);
    localparam int SLOTS = 2 * MAX_SYMBOLS - 1;
    localparam int NW    = $clog2(SLOTS + 1);
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int SW    = $clog2(MAX_SYMBOLS);
    localparam int WW    = FREQ_W + $clog2(MAX_SYMBOLS) + 1;

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_MSTART = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_MWRITE = 4'd3;
    localparam logic [3:0] ST_WINIT  = 4'd4;
    localparam logic [3:0] ST_POP    = 4'd5;
    localparam logic [3:0] ST_PWAIT  = 4'd6;
    localparam logic [3:0] ST_VISIT  = 4'd7;
    localparam logic [3:0] ST_PUSH2  = 4'd8;

    typedef struct packed {
        logic [NW-1:0]     node;
        logic [LEN_W-1:0]  depth;
        logic [CODE_W-1:0] code;
    } entry_t;

    // Memories.
    logic [WW-1:0]     weight_mem [SLOTS];
    logic [2*NW-1:0]   child_mem  [SLOTS];
    logic [SYM_W-1:0]  sym_mem    [MAX_SYMBOLS];
    entry_t            stack_mem  [MAX_SYMBOLS];

    logic [WW-1:0]     weight_q;
    logic [2*NW-1:0]   child_q;
    logic [SYM_W-1:0]  sym_q;
    entry_t            stack_q;

    logic              w_we;
    logic [NW-1:0]     w_addr;
    logic [WW-1:0]     w_data;
    logic [NW-1:0]     w_raddr;
    logic              c_we;
    logic [2*NW-1:0]   c_data;
    logic              st_we;
    logic [SW-1:0]     st_waddr;
    logic [SW-1:0]     st_raddr;
    entry_t            st_wdata;
    logic              sym_we;

    // Control and working registers.
    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [NW-1:0]     nc_reg, nc_next;
    logic [CW-1:0]     act_reg, act_next;
    logic [SLOTS-1:0]  active_reg, active_next;
    logic [NW-1:0]     scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [NW-1:0]     pidx_reg, pidx_next;
    logic              b1v_reg, b1v_next, b2v_reg, b2v_next;
    logic [NW-1:0]     b1i_reg, b1i_next, b2i_reg, b2i_next;
    logic [WW-1:0]     b1w_reg, b1w_next, b2w_reg, b2w_next;
    logic [CW-1:0]     sp_reg, sp_next;
    entry_t            ent_reg, ent_next;
    logic              mv_reg, mv_next;
    logic [SYM_W-1:0]  msym_reg, msym_next;
    logic [CODE_W-1:0] mcode_reg, mcode_next;
    logic [LEN_W-1:0]  mlen_reg, mlen_next;
    logic              mlast_reg, mlast_next;

    logic              in_acc;
    logic [CW-1:0]     cnt_inc;
    logic              is_leaf;
    logic [CODE_W-1:0] code_shift;

    always_ff @(posedge aclk) begin
        if (w_we) begin
            weight_mem[w_addr] <= w_data;
        end
        if (c_we) begin
            child_mem[nc_reg] <= c_data;
        end
        if (sym_we) begin
            sym_mem[cnt_reg[SW-1:0]] <= s_tdata[SYM_W-1:0];
        end
        if (st_we) begin
            stack_mem[st_waddr] <= st_wdata;
        end
        weight_q <= weight_mem[w_raddr];
        child_q  <= child_mem[ent_next.node];
        sym_q    <= sym_mem[ent_next.node[SW-1:0]];
        stack_q  <= stack_mem[st_raddr];
    end

    assign s_tready   = (state_reg == ST_LOAD);
    assign in_acc     = s_tvalid && s_tready;
    assign cnt_inc    = cnt_reg + 1'b1;
    assign is_leaf    = ((NW + 1)'(ent_reg.node) < (NW + 1)'(n_reg));
    assign code_shift = {ent_reg.code[CODE_W-2:0], 1'b0};

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        nc_next     = nc_reg;
        act_next    = act_reg;
        active_next = active_reg;
        scan_next   = scan_reg;
        pend_next   = 1'b0;
        pidx_next   = scan_reg;
        b1v_next    = b1v_reg;
        b1i_next    = b1i_reg;
        b1w_next    = b1w_reg;
        b2v_next    = b2v_reg;
        b2i_next    = b2i_reg;
        b2w_next    = b2w_reg;
        sp_next     = sp_reg;
        ent_next    = ent_reg;
        mv_next     = mv_reg && !m_tready;
        msym_next   = msym_reg;
        mcode_next  = mcode_reg;
        mlen_next   = mlen_reg;
        mlast_next  = mlast_reg;
        w_we        = 1'b0;
        w_addr      = nc_reg;
        w_data      = b1w_reg + b2w_reg;
        w_raddr     = scan_reg;
        c_we        = 1'b0;
        c_data      = {b1i_reg, b2i_reg};
        sym_we      = 1'b0;
        st_we       = 1'b0;
        st_waddr    = sp_reg[SW-1:0];
        st_raddr    = SW'(sp_reg - 1'b1);
        st_wdata    = ent_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (cnt_reg < CW'(MAX_SYMBOLS)) begin
                        w_we     = 1'b1;
                        w_addr   = NW'(cnt_reg);
                        w_data   = WW'(s_tdata[SYM_W+FREQ_W-1:SYM_W]);
                        sym_we   = 1'b1;
                        active_next[NW'(cnt_reg)] = 1'b1;
                        cnt_next = cnt_inc;
                    end
                    if (s_tlast) begin
                        n_next     = (cnt_reg < CW'(MAX_SYMBOLS)) ? cnt_inc : cnt_reg;
                        nc_next    = NW'(n_next);
                        act_next   = n_next;
                        state_next = ST_MSTART;
                    end
                end
            end
            ST_MSTART: begin
                scan_next = '0;
                b1v_next  = 1'b0;
                b2v_next  = 1'b0;
                state_next = (act_reg > CW'(1)) ? ST_SCAN : ST_WINIT;
            end
            ST_SCAN: begin
                // Weight data arriving now belongs to the index issued last cycle.
                if (pend_reg && active_reg[pidx_reg]) begin
                    if (!b1v_reg || weight_q < b1w_reg) begin
                        b2v_next = b1v_reg;
                        b2i_next = b1i_reg;
                        b2w_next = b1w_reg;
                        b1v_next = 1'b1;
                        b1i_next = pidx_reg;
                        b1w_next = weight_q;
                    end else if (!b2v_reg || weight_q < b2w_reg) begin
                        b2v_next = 1'b1;
                        b2i_next = pidx_reg;
                        b2w_next = weight_q;
                    end
                end
                if (scan_reg < nc_reg) begin
                    pend_next = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_MWRITE;
                end
            end
            ST_MWRITE: begin
                w_we = 1'b1;
                c_we = 1'b1;
                active_next[b1i_reg] = 1'b0;
                active_next[b2i_reg] = 1'b0;
                active_next[nc_reg]  = 1'b1;
                nc_next    = nc_reg + 1'b1;
                act_next   = act_reg - 1'b1;
                state_next = ST_MSTART;
            end
            ST_WINIT: begin
                st_we      = 1'b1;
                st_waddr   = '0;
                st_wdata   = '{node: nc_reg - 1'b1, depth: '0, code: '0};
                sp_next    = CW'(1);
                state_next = ST_POP;
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    active_next = '0;
                    cnt_next    = '0;
                    nc_next     = '0;
                    state_next  = ST_LOAD;
                end else begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT: begin
                ent_next   = stack_q;
                state_next = ST_VISIT;
            end
            ST_VISIT: begin
                if (is_leaf) begin
                    if (!mv_reg || m_tready) begin
                        mv_next    = 1'b1;
                        msym_next  = sym_q;
                        mcode_next = ent_reg.code;
                        mlen_next  = ent_reg.depth;
                        mlast_next = (sp_reg == '0);
                        state_next = ST_POP;
                    end
                end else begin
                    st_we      = 1'b1;
                    st_wdata   = '{node: child_q[NW-1:0], depth: ent_reg.depth + 1'b1,
                                   code: code_shift | CODE_W'(1)};
                    sp_next    = sp_reg + 1'b1;
                    state_next = ST_PUSH2;
                end
            end
            ST_PUSH2: begin
                st_we      = 1'b1;
                st_wdata   = '{node: child_q[2*NW-1:NW], depth: ent_reg.depth + 1'b1,
                               code: code_shift};
                sp_next    = sp_reg + 1'b1;
                state_next = ST_POP;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            n_reg      <= '0;
            nc_reg     <= '0;
            act_reg    <= '0;
            active_reg <= '0;
            scan_reg   <= '0;
            pend_reg   <= 1'b0;
            b1v_reg    <= 1'b0;
            b2v_reg    <= 1'b0;
            sp_reg     <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            nc_reg     <= nc_next;
            act_reg    <= act_next;
            active_reg <= active_next;
            scan_reg   <= scan_next;
            pend_reg   <= pend_next;
            b1v_reg    <= b1v_next;
            b2v_reg    <= b2v_next;
            sp_reg     <= sp_next;
            mv_reg     <= mv_next;
        end
        pidx_reg  <= pidx_next;
        b1i_reg   <= b1i_next;
        b1w_reg   <= b1w_next;
        b2i_reg   <= b2i_next;
        b2w_reg   <= b2w_next;
        ent_reg   <= ent_next;
        msym_reg  <= msym_next;
        mcode_reg <= mcode_next;
        mlen_reg  <= mlen_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = OUT_DATA_W'({mlen_reg, mcode_reg, msym_reg});

    // A merge always finds two distinct active nodes.
    a_two_picked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MWRITE) |-> (b1v_reg && b2v_reg && b1i_reg != b2i_reg))
        else $error("merge without two distinct active nodes");

    // The walk stack never grows past its depth.
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= CW'(MAX_SYMBOLS))
        else $error("walk stack overflow");

    // New merged nodes always land inside the node store.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MWRITE) |-> ((NW + 1)'(nc_reg) < (NW + 1)'(SLOTS)))
        else $error("node store overflow");

    // The number of active nodes matches the merge counter while merging.
    a_active_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MSTART) |-> ($countones(active_reg) == int'(act_reg)))
        else $error("active node count mismatch");
endmodule
